@@ sv/tlj_pkg.sv @@
`timescale 1ns / 1ps

package tlj_pkg;

   // Field widths
   localparam int LEN_W = 7;
   localparam int SP_W  = 6;

   // Line geometry
   localparam int MAX_LINE_WIDTH = 64;
   localparam int MAX_LINE_WORDS = 32;
   localparam logic [LEN_W-1:0] RESET_LINE_WIDTH = 7'd16;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DIV,
      S_RD,
      S_LOAD,
      S_HOLD,
      S_PLACE,
      S_SOLO
   } state_type;

endpackage

@@ sv/tlj_channels.sv @@
`timescale 1ns / 1ps

// Word beat: one incoming word length
interface tlj_req_if;
   logic                       valid;
   logic                       ready;
   logic [tlj_pkg::LEN_W-1:0]  word_length;
   logic                       last_word;

   modport source (output valid, output word_length, output last_word, input ready);
   modport sink   (input valid, input word_length, input last_word, output ready);
endinterface

// Result beat: one placed word
interface tlj_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [tlj_pkg::LEN_W-1:0]  out_length;
   logic [tlj_pkg::SP_W-1:0]   spaces_after;
   logic                       line_end;
   logic                       too_long;
   logic                       last;

   modport source (output valid, output out_length, output spaces_after, output line_end,
                   output too_long, output last, input ready);
   modport sink   (input valid, input out_length, input spaces_after, input line_end,
                   input too_long, input last, output ready);
endinterface

// Register write beat: line width
interface tlj_csr_if;
   logic                       valid;
   logic                       ready;
   logic [tlj_pkg::LEN_W-1:0]  line_width;

   modport source (output valid, output line_width, input ready);
   modport sink   (input valid, input line_width, output ready);
endinterface

@@ sv/tlj_ram.sv @@
`timescale 1ns / 1ps

module tlj_ram #(
   parameter int WIDTH = tlj_pkg::LEN_W,
   parameter int DEPTH = tlj_pkg::MAX_LINE_WORDS,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/tlj_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle
module tlj_div #(
   parameter int DVD_W = tlj_pkg::LEN_W,
   parameter int DVS_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quot,
   output logic [DVS_W-1:0] rem
);

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;
   logic              ge;

   // Shift in the next dividend bit and try a subtract
   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign ge    = (trial >= {1'b0, dvs_ff});
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DVD_W);
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         step_in = step_ff - STEP_W'(1);
         dvd_in  = {dvd_ff[DVD_W-2:0], ge};
         rem_in  = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quot = dvd_ff;
   assign rem  = rem_ff;

endmodule

@@ sv/text_line_justifier_top.sv @@
`timescale 1ns / 1ps
// A word that only joins the buffered line passes the check and place states before the
// input is ready again. A line flush of n words takes each word beat through RAM read,
// load and hand over (which waits for rsp.ready), after a run of the shared serial divider
// when a justified line has two or more words. One word is in flight at a time.
// Reset (synchronous, active high) empties the line and sets the width to 16; the word
// buffer is not cleared and needs no clearing pass.
module text_line_justifier_top #(
   parameter int MAX_LINE_WORDS = tlj_pkg::MAX_LINE_WORDS
) (
   input  logic      clock,
   input  logic      reset,
   tlj_req_if.sink   req,
   tlj_rsp_if.source rsp,
   tlj_csr_if.sink   csr
);

   localparam int LEN_W = tlj_pkg::LEN_W;
   localparam int SP_W  = tlj_pkg::SP_W;
   localparam int CNT_W = $clog2(MAX_LINE_WORDS + 1);
   localparam int IDX_W = (MAX_LINE_WORDS > 1) ? $clog2(MAX_LINE_WORDS) : 1;

   tlj_pkg::state_type state_ff, state_in;

   logic [LEN_W-1:0] line_width_ff;
   logic [LEN_W-1:0] eff_w;

   logic [LEN_W-1:0] wl_ff, wl_in;
   logic             fin_ff, fin_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0] used_ff, used_in;
   logic [LEN_W-1:0] letters_ff, letters_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             final_ff, final_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0] out_length_ff, out_length_in;
   logic [SP_W-1:0]  spaces_ff, spaces_in;
   logic             line_end_ff, line_end_in;
   logic             too_long_ff, too_long_in;
   logic             last_ff, last_in;

   logic             ram_we;
   logic [LEN_W-1:0] ram_rdata;
   logic             div_start;
   logic             div_done;
   logic [LEN_W-1:0] div_quot;
   logic [CNT_W-1:0] div_rem;

   logic [LEN_W:0]   need_width;
   logic             full;
   logic             need_flush;
   logic             fits;
   logic             idx_last;
   logic             extra;
   logic [LEN_W-1:0] spare;
   logic [LEN_W-1:0] pad;

   // Register write port, ready only between words
   assign csr.ready = (state_ff == tlj_pkg::S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= tlj_pkg::RESET_LINE_WIDTH;
      end else if (csr.valid && csr.ready) begin
         line_width_ff <= csr.line_width;
      end
   end

   // Clamp the width into the legal range
   always_comb begin
      priority if (line_width_ff == '0) begin
         eff_w = LEN_W'(1);
      end else if (line_width_ff > LEN_W'(tlj_pkg::MAX_LINE_WIDTH)) begin
         eff_w = LEN_W'(tlj_pkg::MAX_LINE_WIDTH);
      end else begin
         eff_w = line_width_ff;
      end
   end

   // Fit test and spacing arithmetic
   assign need_width = {1'b0, used_ff} + (LEN_W+1)'(1) + {1'b0, wl_ff};
   assign full       = (count_ff >= CNT_W'(MAX_LINE_WORDS));
   assign need_flush = (count_ff != '0) && ((need_width > {1'b0, eff_w}) || full);
   assign fits       = (wl_ff <= eff_w);
   assign idx_last   = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign extra      = (CNT_W'(idx_ff) < div_rem);
   assign spare      = (eff_w > letters_ff) ? (eff_w - letters_ff) : '0;
   assign pad        = (eff_w > used_ff) ? (eff_w - used_ff) : '0;

   // Word buffer
   tlj_ram #(
      .WIDTH (LEN_W),
      .DEPTH (MAX_LINE_WORDS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[IDX_W-1:0]),
      .wdata (wl_ff),
      .raddr (idx_ff),
      .rdata (ram_rdata)
   );

   // Shared divider: spare spaces over the gaps
   tlj_div #(
      .DVD_W (LEN_W),
      .DVS_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (spare),
      .divisor  (count_ff - CNT_W'(1)),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   assign req.ready = (state_ff == tlj_pkg::S_IDLE);

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in      = state_ff;
      wl_in         = wl_ff;
      fin_in        = fin_ff;
      count_in      = count_ff;
      used_in       = used_ff;
      letters_in    = letters_ff;
      idx_in        = idx_ff;
      final_in      = final_ff;
      rsp_valid_in  = rsp_valid_ff;
      out_length_in = out_length_ff;
      spaces_in     = spaces_ff;
      line_end_in   = line_end_ff;
      too_long_in   = too_long_ff;
      last_in       = last_ff;
      ram_we        = 1'b0;
      div_start     = 1'b0;

      unique case (state_ff)
         tlj_pkg::S_IDLE: begin
            if (req.valid) begin
               wl_in    = (req.word_length == '0) ? LEN_W'(1) : req.word_length;
               fin_in   = req.last_word;
               state_in = tlj_pkg::S_CHECK;
            end
         end
         tlj_pkg::S_CHECK: begin
            // Flush the buffered line when the word does not fit or the buffer is full
            if (need_flush) begin
               final_in = 1'b0;
               idx_in   = '0;
               if (count_ff == CNT_W'(1)) begin
                  state_in = tlj_pkg::S_RD;
               end else begin
                  div_start = 1'b1;
                  state_in  = tlj_pkg::S_DIV;
               end
            end else begin
               state_in = tlj_pkg::S_PLACE;
            end
         end
         tlj_pkg::S_DIV: begin
            if (div_done) begin
               state_in = tlj_pkg::S_RD;
            end
         end
         tlj_pkg::S_RD: begin
            state_in = tlj_pkg::S_LOAD;
         end
         tlj_pkg::S_LOAD: begin
            rsp_valid_in  = 1'b1;
            out_length_in = ram_rdata;
            line_end_in   = idx_last;
            too_long_in   = 1'b0;
            last_in       = idx_last && (final_ff || (fits && !fin_ff));
            priority if (final_ff) begin
               spaces_in = idx_last ? pad[SP_W-1:0] : SP_W'(1);
            end else if (count_ff == CNT_W'(1)) begin
               spaces_in = spare[SP_W-1:0];
            end else if (idx_last) begin
               spaces_in = '0;
            end else begin
               spaces_in = div_quot[SP_W-1:0] + SP_W'(extra);
            end
            state_in = tlj_pkg::S_HOLD;
         end
         tlj_pkg::S_HOLD: begin
            if (rsp.ready) begin
               rsp_valid_in = 1'b0;
               if (!idx_last) begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = tlj_pkg::S_RD;
               end else begin
                  // Drop the emitted line
                  count_in   = '0;
                  used_in    = '0;
                  letters_in = '0;
                  state_in   = final_ff ? tlj_pkg::S_IDLE : tlj_pkg::S_PLACE;
               end
            end
         end
         tlj_pkg::S_PLACE: begin
            if (!fits) begin
               // Oversized word goes out alone
               rsp_valid_in  = 1'b1;
               out_length_in = wl_ff;
               spaces_in     = '0;
               line_end_in   = 1'b1;
               too_long_in   = 1'b1;
               last_in       = 1'b1;
               state_in      = tlj_pkg::S_SOLO;
            end else begin
               // Append the word to the line
               ram_we     = 1'b1;
               used_in    = (count_ff == '0) ? wl_ff : need_width[LEN_W-1:0];
               letters_in = letters_ff + wl_ff;
               count_in   = count_ff + CNT_W'(1);
               if (fin_ff) begin
                  final_in = 1'b1;
                  idx_in   = '0;
                  state_in = tlj_pkg::S_RD;
               end else begin
                  state_in = tlj_pkg::S_IDLE;
               end
            end
         end
         tlj_pkg::S_SOLO: begin
            if (rsp.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = tlj_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = tlj_pkg::S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlj_pkg::S_IDLE;
         count_ff     <= '0;
         used_ff      <= '0;
         letters_ff   <= '0;
         idx_ff       <= '0;
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         used_ff      <= used_in;
         letters_ff   <= letters_in;
         idx_ff       <= idx_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      wl_ff         <= wl_in;
      fin_ff        <= fin_in;
      out_length_ff <= out_length_in;
      spaces_ff     <= spaces_in;
      line_end_ff   <= line_end_in;
      too_long_ff   <= too_long_in;
      last_ff       <= last_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.out_length   = out_length_ff;
   assign rsp.spaces_after = spaces_ff;
   assign rsp.line_end     = line_end_ff;
   assign rsp.too_long     = too_long_ff;
   assign rsp.last         = last_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_LINE_WORDS))
      else $error("line buffer count exceeds capacity");

   a_width_bound: assert property (@(posedge clock) disable iff (reset)
      (letters_ff <= used_ff) && (used_ff <= LEN_W'(tlj_pkg::MAX_LINE_WIDTH)))
      else $error("line width bookkeeping out of range");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp.valid && req.ready))
      else $error("input taken while a result is pending");

   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.last) |-> rsp.line_end)
      else $error("final result of a word does not close a line");

   a_div_gaps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tlj_pkg::S_DIV) |-> (count_ff > CNT_W'(1)))
      else $error("divider running with no gap");

endmodule
